// File: hdl/gstmg_pkg.sv
// Package with shared constants and types for the grid spanning tree maze generator.
package gstmg_pkg;

    localparam int MaxRows = 32;
    localparam int MaxCols = 32;
    localparam int CellLimit = MaxRows * MaxCols;
    localparam int WallLimit = 2 * CellLimit;
    localparam int CellW = $clog2(CellLimit);
    localparam int WallW = $clog2(WallLimit);
    localparam int CodeW = CellW + 1;
    localparam int SizeW = 6;
    localparam int RandW = 32;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_SHUFFLE = 2'd1;
    localparam logic [1:0] PH_SCAN    = 2'd2;
    localparam logic [1:0] PH_DONE    = 2'd3;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    typedef struct packed {
        logic             start;
        logic [RandW-1:0] dividend;
        logic [WallW:0]   divisor;
    } mod_req_t;

endpackage

// File: hdl/grid_spanning_tree_maze_generator.sv
// Top level: sequencer, wall and parent memories of the randomized Kruskal maze generator.
// One request is handled at a time. A restart request builds the wall list, a right wall
// and then a down wall for each cell that has them, and then resets all 1024 parent
// entries at one per cycle before its result is given. A shuffle request's result
// follows the bit-serial modulo unit and the two reads and two writes of the swap. A scan
// request reads its wall and then does parent lookups along both root chains, each
// chain needing one lookup more than its length. An idle or done request's result
// appears in the next cycle. A new request is taken only in the idle state and only
// when the output register is empty or is being read in the same cycle.
module grid_spanning_tree_maze_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,   // restart[0]
    input  logic [31:0] s_tdata,   // random_word[31:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,   // phase[1:0]
    output logic [23:0] m_tdata,   // wall_first_cell[9:0], wall_second_cell[19:10], kept[20], zero pad
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [5:0]  cfg_data
);

    localparam int CellW = gstmg_pkg::CellW;
    localparam int WallW = gstmg_pkg::WallW;
    localparam int CodeW = gstmg_pkg::CodeW;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_BUILD  = 4'd1;
    localparam logic [3:0] S_CLEAR  = 4'd2;
    localparam logic [3:0] S_MOD    = 4'd3;
    localparam logic [3:0] S_SRDI   = 4'd4;
    localparam logic [3:0] S_SRDJ   = 4'd5;
    localparam logic [3:0] S_SWAP   = 4'd6;
    localparam logic [3:0] S_WRD    = 4'd7;
    localparam logic [3:0] S_WWAIT  = 4'd8;
    localparam logic [3:0] S_PRD    = 4'd9;
    localparam logic [3:0] S_PWAIT  = 4'd10;
    localparam logic [3:0] S_PCHK   = 4'd11;
    localparam logic [3:0] S_EMIT   = 4'd12;

    logic [3:0]       state_reg, state_next;
    logic [5:0]       rows_cfg_reg, rows_cfg_next, cols_cfg_reg, cols_cfg_next;
    logic [5:0]       run_rows_reg, run_rows_next, run_cols_reg, run_cols_next;
    logic [1:0]       phase_reg, phase_next;
    logic [WallW-1:0] shuf_reg, shuf_next, scan_reg, scan_next;
    logic [WallW:0]   walls_reg, walls_next;
    logic [WallW:0]   wcnt_reg, wcnt_next;
    logic [CellW-1:0] cell_reg, cell_next;
    logic [5:0]       r_reg, r_next, c_reg, c_next;
    logic             pend_down_reg, pend_down_next;
    logic [CellW:0]   clr_reg, clr_next;
    logic [WallW-1:0] j_reg, j_next;
    logic [CodeW-1:0] wi_reg, wi_next;
    logic [CellW-1:0] first_reg, first_next, second_reg, second_next;
    logic [CellW-1:0] walk_reg, walk_next, ra_reg, ra_next;
    logic             side_reg, side_next;
    logic [CellW:0]   steps_reg, steps_next;
    logic             m_valid_reg, m_valid_next;
    logic [23:0]      m_data_reg, m_data_next;

    logic             w_we;
    logic [WallW-1:0] w_waddr, w_raddr;
    logic [CodeW-1:0] w_wdata, w_rdata;
    logic             p_we;
    logic [CellW-1:0] p_waddr, p_wdata, p_raddr, p_rdata;

    gstmg_pkg::mod_req_t mreq;
    logic                mdone;
    logic [WallW:0]      mrem;

    logic             in_fire;
    logic             restart_in;
    logic [31:0]      rnd_in;
    logic [5:0]       nr, nc;
    logic [WallW+1:0] wall_total;
    logic             build_step;

    gstmg_ram #(.Width(CodeW), .Depth(gstmg_pkg::WallLimit)) u_wall_ram (
        .aclk(aclk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
        .raddr(w_raddr), .rdata(w_rdata)
    );

    gstmg_ram #(.Width(CellW), .Depth(gstmg_pkg::CellLimit)) u_parent_ram (
        .aclk(aclk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    gstmg_mod u_mod (
        .aclk(aclk), .aresetn(aresetn), .req(mreq), .done(mdone), .remainder(mrem)
    );

    assign s_tready = (state_reg == S_IDLE) && (!m_valid_reg || m_tready);
    assign in_fire = s_tvalid && s_tready;
    assign restart_in = s_tuser;
    assign rnd_in = s_tdata;
    assign m_tvalid = m_valid_reg;
    assign m_tuser = m_data_reg[1:0];
    assign m_tdata = {3'd0, m_data_reg[22:2]};
    assign m_tlast = m_data_reg[23];

    always_comb begin
        nr = rows_cfg_reg;
        nc = cols_cfg_reg;
        if (nr == 6'd0) begin
            nr = 6'd1;
        end else if (nr > 6'(gstmg_pkg::MaxRows)) begin
            nr = 6'(gstmg_pkg::MaxRows);
        end
        if (nc == 6'd0) begin
            nc = 6'd1;
        end else if (nc > 6'(gstmg_pkg::MaxCols)) begin
            nc = 6'(gstmg_pkg::MaxCols);
        end
        wall_total = (WallW+2)'(nr) * (WallW+2)'(nc - 6'd1)
                   + (WallW+2)'(nc) * (WallW+2)'(nr - 6'd1);
    end

    always_comb begin
        state_next = state_reg;
        rows_cfg_next = rows_cfg_reg;
        cols_cfg_next = cols_cfg_reg;
        run_rows_next = run_rows_reg;
        run_cols_next = run_cols_reg;
        phase_next = phase_reg;
        shuf_next = shuf_reg;
        scan_next = scan_reg;
        walls_next = walls_reg;
        wcnt_next = wcnt_reg;
        cell_next = cell_reg;
        r_next = r_reg;
        c_next = c_reg;
        pend_down_next = pend_down_reg;
        clr_next = clr_reg;
        j_next = j_reg;
        wi_next = wi_reg;
        first_next = first_reg;
        second_next = second_reg;
        walk_next = walk_reg;
        ra_next = ra_reg;
        side_next = side_reg;
        steps_next = steps_reg;
        m_valid_next = m_valid_reg;
        m_data_next = m_data_reg;
        build_step = 1'b0;
        w_we = 1'b0;
        w_waddr = '0;
        w_wdata = '0;
        w_raddr = '0;
        p_we = 1'b0;
        p_waddr = '0;
        p_wdata = '0;
        p_raddr = walk_reg;
        mreq.start = 1'b0;
        mreq.dividend = rnd_in;
        mreq.divisor = (WallW+1)'(shuf_reg) + 1'b1;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (cfg_we) begin
            unique case (cfg_index)
                gstmg_pkg::CFG_ROWS: rows_cfg_next = cfg_data;
                gstmg_pkg::CFG_COLS: cols_cfg_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    if (restart_in) begin
                        run_rows_next = nr;
                        run_cols_next = nc;
                        walls_next = wall_total[WallW:0];
                        wcnt_next = '0;
                        cell_next = '0;
                        r_next = '0;
                        c_next = '0;
                        pend_down_next = 1'b0;
                        clr_next = '0;
                        scan_next = '0;
                        state_next = S_BUILD;
                    end else if (phase_reg == gstmg_pkg::PH_SHUFFLE) begin
                        mreq.start = 1'b1;
                        state_next = S_MOD;
                    end else if (phase_reg == gstmg_pkg::PH_SCAN) begin
                        state_next = S_WRD;
                    end else begin
                        m_valid_next = 1'b1;
                        m_data_next = {22'd0, phase_reg};
                    end
                end
            end
            S_BUILD: begin
                // At most one wall write per cycle; a down wall pending after a right wall.
                if (pend_down_reg) begin
                    w_we = 1'b1;
                    w_waddr = wcnt_reg[WallW-1:0];
                    w_wdata = {cell_reg, 1'b1};
                    wcnt_next = wcnt_reg + 1'b1;
                    pend_down_next = 1'b0;
                    build_step = 1'b1;
                end else if (r_reg == run_rows_reg) begin
                    state_next = S_CLEAR;
                end else begin
                    if (c_reg + 6'd1 < run_cols_reg) begin
                        w_we = 1'b1;
                        w_waddr = wcnt_reg[WallW-1:0];
                        w_wdata = {cell_reg, 1'b0};
                        wcnt_next = wcnt_reg + 1'b1;
                        pend_down_next = (r_reg + 6'd1 < run_rows_reg);
                        build_step = !(r_reg + 6'd1 < run_rows_reg);
                    end else if (r_reg + 6'd1 < run_rows_reg) begin
                        w_we = 1'b1;
                        w_waddr = wcnt_reg[WallW-1:0];
                        w_wdata = {cell_reg, 1'b1};
                        wcnt_next = wcnt_reg + 1'b1;
                        build_step = 1'b1;
                    end else begin
                        build_step = 1'b1;
                    end
                end
                if (build_step) begin
                    cell_next = cell_reg + 1'b1;
                    if (c_reg + 6'd1 == run_cols_reg) begin
                        c_next = '0;
                        r_next = r_reg + 6'd1;
                    end else begin
                        c_next = c_reg + 6'd1;
                    end
                end
            end
            S_CLEAR: begin
                p_we = 1'b1;
                p_waddr = clr_reg[CellW-1:0];
                p_wdata = clr_reg[CellW-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (CellW+1)'(gstmg_pkg::CellLimit - 1)) begin
                    state_next = S_IDLE;
                    m_valid_next = 1'b1;
                    if (walls_reg == '0) begin
                        phase_next = gstmg_pkg::PH_DONE;
                        shuf_next = '0;
                    end else if (walls_reg == (WallW+1)'(1)) begin
                        phase_next = gstmg_pkg::PH_SCAN;
                        shuf_next = '0;
                    end else begin
                        phase_next = gstmg_pkg::PH_SHUFFLE;
                        shuf_next = WallW'(walls_reg - 1'b1);
                    end
                    m_data_next = {22'd0, phase_next};
                end
            end
            S_MOD: begin
                if (mdone) begin
                    j_next = mrem[WallW-1:0];
                    state_next = S_SRDI;
                end
            end
            S_SRDI: begin
                w_raddr = shuf_reg;
                state_next = S_SRDJ;
            end
            S_SRDJ: begin
                w_raddr = j_reg;
                wi_next = w_rdata;
                state_next = S_SWAP;
            end
            S_SWAP: begin
                // Writes i<-w[j] here, then j<-w[i] in IDLE-bound finish below.
                w_we = 1'b1;
                w_waddr = shuf_reg;
                w_wdata = w_rdata;
                wi_next = wi_reg;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                w_we = 1'b1;
                w_waddr = j_reg;
                w_wdata = wi_reg;
                m_valid_next = 1'b1;
                m_data_next = {22'd0, gstmg_pkg::PH_SHUFFLE};
                if (shuf_reg <= WallW'(1)) begin
                    shuf_next = '0;
                    phase_next = gstmg_pkg::PH_SCAN;
                end else begin
                    shuf_next = shuf_reg - 1'b1;
                end
                state_next = S_IDLE;
            end
            S_WRD: begin
                w_raddr = scan_reg;
                state_next = S_WWAIT;
            end
            S_WWAIT: begin
                first_next = w_rdata[CodeW-1:1];
                if (w_rdata[0]) begin
                    second_next = w_rdata[CodeW-1:1] + CellW'(run_cols_reg);
                end else begin
                    second_next = w_rdata[CodeW-1:1] + 1'b1;
                end
                walk_next = w_rdata[CodeW-1:1];
                side_next = 1'b0;
                steps_next = '0;
                state_next = S_PRD;
            end
            S_PRD: begin
                p_raddr = walk_reg;
                state_next = S_PWAIT;
            end
            S_PWAIT: begin
                state_next = S_PCHK;
            end
            S_PCHK: begin
                if (p_rdata != walk_reg
                        && steps_reg < (CellW+1)'(gstmg_pkg::CellLimit)) begin
                    walk_next = p_rdata;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_PRD;
                end else if (!side_reg) begin
                    ra_next = walk_reg;
                    walk_next = second_reg;
                    side_next = 1'b1;
                    steps_next = '0;
                    state_next = S_PRD;
                end else begin
                    m_valid_next = 1'b1;
                    m_data_next[1:0] = gstmg_pkg::PH_SCAN;
                    m_data_next[11:2] = 10'(first_reg);
                    m_data_next[21:12] = 10'(second_reg);
                    m_data_next[22] = (ra_reg != walk_reg);
                    if (ra_reg != walk_reg) begin
                        p_we = 1'b1;
                        p_waddr = walk_reg;
                        p_wdata = ra_reg;
                    end
                    if ((WallW+1)'(scan_reg) + 1'b1 >= walls_reg) begin
                        m_data_next[23] = 1'b1;
                        scan_next = '0;
                        phase_next = gstmg_pkg::PH_DONE;
                    end else begin
                        m_data_next[23] = 1'b0;
                        scan_next = scan_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            clr_reg <= '0;
            rows_cfg_reg <= 6'd8;
            cols_cfg_reg <= 6'd8;
            run_rows_reg <= 6'd8;
            run_cols_reg <= 6'd8;
            phase_reg <= gstmg_pkg::PH_IDLE;
            shuf_reg <= '0;
            scan_reg <= '0;
            walls_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            rows_cfg_reg <= rows_cfg_next;
            cols_cfg_reg <= cols_cfg_next;
            run_rows_reg <= run_rows_next;
            run_cols_reg <= run_cols_next;
            shuf_reg <= shuf_next;
            scan_reg <= scan_next;
            walls_reg <= walls_next;
            phase_reg <= phase_next;
            m_valid_reg <= m_valid_next;
        end
        wcnt_reg <= wcnt_next;
        cell_reg <= cell_next;
        r_reg <= r_next;
        c_reg <= c_next;
        pend_down_reg <= pend_down_next;
        j_reg <= j_next;
        wi_reg <= wi_next;
        first_reg <= first_next;
        second_reg <= second_next;
        walk_reg <= walk_next;
        ra_reg <= ra_next;
        side_reg <= side_next;
        steps_reg <= steps_next;
        m_data_reg <= m_data_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && (restart_in || phase_reg == gstmg_pkg::PH_SHUFFLE
                     || phase_reg == gstmg_pkg::PH_SCAN)) |=> !s_tready)
        else $error("input accepted while busy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_data_reg[22]) |-> (m_data_reg[1:0] == gstmg_pkg::PH_SCAN))
        else $error("kept flag outside scan phase");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_data_reg)))
        else $error("result dropped or changed while waiting");

endmodule

// File: hdl/gstmg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module gstmg_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/gstmg_mod.sv
// Bit-serial restoring modulo unit, one quotient bit per cycle.
module gstmg_mod (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gstmg_pkg::mod_req_t           req,
    output logic                          done,
    output logic [gstmg_pkg::WallW:0]     remainder
);

    localparam int RemW = gstmg_pkg::WallW + 2;

    logic [gstmg_pkg::RandW-1:0] shift_reg, shift_next;
    logic [RemW-1:0]             rem_reg, rem_next;
    logic [5:0]                  count_reg, count_next;
    logic                        busy_reg, busy_next;
    logic [RemW-1:0]             trial;

    always_comb begin
        shift_next = shift_reg;
        rem_next = rem_reg;
        count_next = count_reg;
        busy_next = busy_reg;
        trial = {rem_reg[RemW-2:0], shift_reg[gstmg_pkg::RandW-1]};
        if (req.start) begin
            shift_next = req.dividend;
            rem_next = '0;
            count_next = 6'(gstmg_pkg::RandW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            shift_next = {shift_reg[gstmg_pkg::RandW-2:0], 1'b0};
            if (trial >= RemW'(req.divisor)) begin
                rem_next = trial - RemW'(req.divisor);
            end else begin
                rem_next = trial;
            end
            count_next = count_reg - 6'd1;
            if (count_reg == 6'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            count_reg <= count_next;
        end
        shift_reg <= shift_next;
        rem_reg <= rem_next;
    end

    assign done = busy_reg && (count_reg == 6'd1);
    assign remainder = rem_next[gstmg_pkg::WallW:0];

endmodule

// File: dv/gstmg_checker.sv
// Checker that predicts the maze generator's results and compares them at the result port.
module gstmg_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        s_tuser,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [1:0]  m_tuser,
    input  logic [23:0] m_tdata,
    input  logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [5:0]  cfg_data,
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       last;
        logic       kept;
        logic [9:0] second_cell;
        logic [9:0] first_cell;
        logic [1:0] phase;
    } maze_result_t;

    logic [gstmg_pkg::CodeW-1:0] walls [gstmg_pkg::WallLimit];
    logic [gstmg_pkg::CellW-1:0] parents [gstmg_pkg::CellLimit];
    int unsigned shuf_idx, scan_idx, wall_total, grid_cols;
    logic [1:0] cur_phase;
    logic [gstmg_pkg::SizeW-1:0] rows_reg, cols_reg;
    maze_result_t expected_results [$];

    function automatic int unsigned clamp_size(logic [gstmg_pkg::SizeW-1:0] v,
                                               int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic int unsigned find_root(int unsigned start_idx);
        int unsigned c;
        int unsigned n;
        c = start_idx % gstmg_pkg::CellLimit;
        n = 0;
        while (parents[c] != c && n < gstmg_pkg::CellLimit) begin
            c = parents[c];
            n++;
        end
        return c;
    endfunction

    function automatic maze_result_t advance_maze(logic restart, logic [31:0] rnd);
        maze_result_t res;
        int unsigned nr, nc, cnt, i, j, ra, rb, cell_idx;
        logic [gstmg_pkg::CodeW-1:0] tmp;
        res = '0;
        if (restart) begin
            nr = clamp_size(rows_reg, gstmg_pkg::MaxRows);
            nc = clamp_size(cols_reg, gstmg_pkg::MaxCols);
            cnt = 0;
            for (int r = 0; r < nr; r++) begin
                for (int c = 0; c < nc; c++) begin
                    cell_idx = r * nc + c;
                    if (c + 1 < nc) walls[cnt++] = gstmg_pkg::CodeW'(cell_idx * 2);
                    if (r + 1 < nr) walls[cnt++] = gstmg_pkg::CodeW'(cell_idx * 2 + 1);
                end
            end
            grid_cols = nc;
            wall_total = cnt;
            for (int k = 0; k < gstmg_pkg::CellLimit; k++) parents[k] = gstmg_pkg::CellW'(k);
            scan_idx = 0;
            shuf_idx = 0;
            if (cnt == 0) cur_phase = gstmg_pkg::PH_DONE;
            else if (cnt == 1) cur_phase = gstmg_pkg::PH_SCAN;
            else begin
                shuf_idx = cnt - 1;
                cur_phase = gstmg_pkg::PH_SHUFFLE;
            end
            res.phase = cur_phase;
        end else if (cur_phase == gstmg_pkg::PH_SHUFFLE) begin
            i = shuf_idx;
            j = rnd % (i + 1);
            tmp = walls[i];
            walls[i] = walls[j];
            walls[j] = tmp;
            res.phase = gstmg_pkg::PH_SHUFFLE;
            if (i <= 1) begin
                shuf_idx = 0;
                cur_phase = gstmg_pkg::PH_SCAN;
            end else begin
                shuf_idx = i - 1;
            end
        end else if (cur_phase == gstmg_pkg::PH_SCAN) begin
            tmp = walls[scan_idx];
            res.first_cell = tmp[gstmg_pkg::CodeW-1:1];
            res.second_cell = tmp[0] ? 10'(res.first_cell + grid_cols)
                                     : 10'(res.first_cell + 1);
            ra = find_root(res.first_cell);
            rb = find_root(res.second_cell);
            if (ra != rb) begin
                parents[rb] = gstmg_pkg::CellW'(ra);
                res.kept = 1'b1;
            end
            res.phase = gstmg_pkg::PH_SCAN;
            if (scan_idx + 1 >= wall_total) begin
                res.last = 1'b1;
                scan_idx = 0;
                cur_phase = gstmg_pkg::PH_DONE;
            end else begin
                scan_idx++;
            end
        end else begin
            res.phase = cur_phase;
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        maze_result_t got, exp_res;
        if (!aresetn) begin
            for (int k = 0; k < gstmg_pkg::CellLimit; k++) parents[k] = gstmg_pkg::CellW'(k);
            shuf_idx = 0;
            scan_idx = 0;
            wall_total = 0;
            grid_cols = 8;
            cur_phase = gstmg_pkg::PH_IDLE;
            rows_reg = 6'd8;
            cols_reg = 6'd8;
            fail_count = 0;
            expected_results.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == gstmg_pkg::CFG_ROWS) rows_reg = cfg_data;
                else cols_reg = cfg_data;
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(advance_maze(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                got = {m_tlast, m_tdata[20], m_tdata[19:10], m_tdata[9:0], m_tuser};
                if (expected_results.size() == 0) begin
                    $error("unexpected result %h", got);
                    fail_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (got.phase != exp_res.phase) begin
                        $error("phase: expected %0d, got %0d", exp_res.phase, got.phase);
                        fail_count++;
                    end
                    if (got.first_cell != exp_res.first_cell) begin
                        $error("wall_first_cell: expected %0d, got %0d",
                               exp_res.first_cell, got.first_cell);
                        fail_count++;
                    end
                    if (got.second_cell != exp_res.second_cell) begin
                        $error("wall_second_cell: expected %0d, got %0d",
                               exp_res.second_cell, got.second_cell);
                        fail_count++;
                    end
                    if (got.kept != exp_res.kept) begin
                        $error("kept: expected %0d, got %0d", exp_res.kept, got.kept);
                        fail_count++;
                    end
                    if (got.last != exp_res.last) begin
                        $error("last: expected %0d, got %0d", exp_res.last, got.last);
                        fail_count++;
                    end
                end
            end
        end
        pending_count = expected_results.size();
    end
endmodule

// File: dv/tb_grid_spanning_tree_maze_generator.sv
// Testbench top: drives restart and random-word requests under varying sizes and stalls.
module tb_grid_spanning_tree_maze_generator;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic        s_tuser = 1'b0;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [1:0]  m_tuser;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic        cfg_index = gstmg_pkg::CFG_ROWS;
    logic [5:0]  cfg_data = '0;
    int          fail_count, pending_count;
    int          send_idle_pct = 0, recv_stall_pct = 0;
    bit          hold_off = 1'b0;
    longint      cycles = 0;

    always #6 aclk = ~aclk;

    grid_spanning_tree_maze_generator dut (.*);

    gstmg_checker checker_i (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd10_000_000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (hold_off) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_request(logic restart, logic [31:0] rnd);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= restart;
        s_tdata <= rnd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_size(logic idx, logic [5:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_maze(int steps);
        send_request(1'b1, $urandom);
        for (int k = 0; k < steps; k++) begin
            if ($urandom_range(99) < 3) send_request(1'b1, $urandom);
            else send_request(1'b0, $urandom);
        end
    endtask

    initial begin
        int sent;
        logic [5:0] r, c;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // Before any restart the block is idle; then a default 8x8 run.
        send_request(1'b0, 32'hFFFF_FFFF);
        send_request(1'b1, 32'h0);
        send_request(1'b0, 32'h0);
        send_request(1'b0, 32'hFFFF_FFFF);
        send_request(1'b0, 32'h8000_0001);
        wait_drained();
        write_size(gstmg_pkg::CFG_ROWS, 6'd1);
        write_size(gstmg_pkg::CFG_COLS, 6'd1);
        send_request(1'b1, 32'h0);
        send_request(1'b0, 32'h5555_5555);
        wait_drained();
        write_size(gstmg_pkg::CFG_COLS, 6'd2);
        send_request(1'b1, 32'h0);
        send_request(1'b0, 32'hAAAA_AAAA);
        send_request(1'b0, 32'h1);
        wait_drained();
        write_size(gstmg_pkg::CFG_ROWS, 6'd0);
        write_size(gstmg_pkg::CFG_COLS, 6'd3);
        for (int k = 0; k < 6; k++) send_request(1'b0 ^ (k == 0), $urandom);
        wait_drained();
        write_size(gstmg_pkg::CFG_COLS, 6'd2);
        send_request(1'b0, 32'h0);
        wait_drained();
        write_size(gstmg_pkg::CFG_ROWS, 6'd63);
        write_size(gstmg_pkg::CFG_COLS, 6'd40);
        send_request(1'b1, 32'h0);
        for (int k = 0; k < 6; k++) send_request(1'b0, $urandom);
        send_request(1'b1, 32'h0);
        wait_drained();

        sent = 0;
        for (int ph = 0; sent < 1650; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 49; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 49; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            if (ph % 5 == 4) begin
                r = 6'($urandom_range(32, 63));
                c = 6'($urandom_range(0, 32));
            end else begin
                r = 6'($urandom_range(0, 5));
                c = 6'($urandom_range(0, 5));
            end
            write_size(gstmg_pkg::CFG_ROWS, r);
            write_size(gstmg_pkg::CFG_COLS, c);
            if (ph == 2) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (3000) @(posedge aclk);
                        hold_off = 1'b0;
                    end
                    run_maze(40);
                join
                sent += 41;
            end else if (ph % 5 == 4) begin
                run_maze(30);
                send_request(1'b0, $urandom);
                sent += 32;
            end else begin
                run_maze(2 * 30 + 30);
                sent += 91;
            end
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// File: sim.f
hdl/gstmg_pkg.sv
hdl/gstmg_ram.sv
hdl/gstmg_mod.sv
hdl/grid_spanning_tree_maze_generator.sv
dv/gstmg_checker.sv
dv/tb_grid_spanning_tree_maze_generator.sv
